// File: src/fpest_pkg.sv
// Shared constants, codes and types of the fixed-point exp/sigmoid/tanh evaluator.
package fpest_pkg;

	// Taylor term limit and the widths that follow from it
	localparam int MAX_TERMS = 31;
	localparam int TERM_W    = $clog2(MAX_TERMS + 1);

	// Field and register widths
	localparam int CFG_W     = 31;
	localparam int CFG_IDX_W = 3;
	localparam int DIV_W     = 64;
	localparam int DIV_CNT_W = $clog2(DIV_W);

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_INPUT_SCALE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_SCALE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TERM_COUNT   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LOG2E        = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LN2          = 3'd4;

	// Register reset values
	localparam logic [CFG_W-1:0] RST_INPUT_SCALE  = 31'd1024;
	localparam logic [CFG_W-1:0] RST_OUTPUT_SCALE = 31'd1024;
	localparam logic [4:0]       RST_TERM_COUNT   = 5'd8;
	localparam logic [CFG_W-1:0] RST_LOG2E        = 31'd1477;
	localparam logic [CFG_W-1:0] RST_LN2          = 31'd710;

	// Function codes
	localparam logic [1:0] CMD_EXP     = 2'd0;
	localparam logic [1:0] CMD_SIGMOID = 2'd1;
	localparam logic [1:0] CMD_TANH    = 2'd2;
	localparam logic [1:0] CMD_NONE    = 2'd3;

	typedef enum logic [4:0] {
		S_IDLE,
		S_PREP,
		S_NMUL,
		S_NDIV1,
		S_NW1,
		S_NDIV2,
		S_NW2,
		S_SNMUL,
		S_T2MUL,
		S_DDIV,
		S_DW,
		S_TCHK,
		S_YDIV1,
		S_YW1,
		S_YDIV2,
		S_YW2,
		S_SDDIV,
		S_SDW,
		S_ASMUL,
		S_ESET,
		S_POST,
		S_PDIV,
		S_PW,
		S_OUT
	} state_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD,
		OP_MUL_XL,
		OP_Q32,
		OP_SETN,
		OP_MUL_SN,
		OP_MUL_T2,
		OP_SETD,
		OP_MUL_YD,
		OP_Y1,
		OP_Y2,
		OP_SHIFT,
		OP_SDIFF,
		OP_MUL_AS,
		OP_SETE,
		OP_EZERO,
		OP_MUL_P,
		OP_RESZ,
		OP_RESE,
		OP_RESQ,
		OP_OUT
	} op_t;

	typedef enum logic [2:0] {
		DIV_P_SI,
		DIV_T_SI,
		DIV_Y_K,
		DIV_OS_SI,
		DIV_P_DEN
	} div_sel_t;

	typedef struct packed {
		op_t      op;
		logic     div_start;
		div_sel_t div_sel;
	} dp_cmd_t;

	typedef struct packed {
		logic [1:0] cmd;
		logic       exp_skip;
		logic       terms_done;
		logic       den_zero;
		logic       div_done;
	} dp_status_t;

endpackage

// File: src/fpest_div.sv
// Shared signed 64-bit restoring divider, one quotient bit per cycle, truncating.
module fpest_div (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic signed [fpest_pkg::DIV_W-1:0] dividend,
	input  logic signed [fpest_pkg::DIV_W-1:0] divisor,
	output logic                               done,
	output logic signed [fpest_pkg::DIV_W-1:0] quotient
);
	import fpest_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIV_W-1:0]     rem_q;
	logic [DIV_W-1:0]     quo_q;
	logic [DIV_W-1:0]     dvs_q;
	logic                 neg_q;
	logic [DIV_W:0]       trial;
	logic [DIV_W:0]       diff;
	logic                 ge;

	// Form the trial remainder for this step
	always_comb begin
		trial = {rem_q, quo_q[DIV_W-1]};
		diff  = trial - {1'b0, dvs_q};
		ge    = !diff[DIV_W];
	end

	// Sequence control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Load magnitudes, then shift one quotient bit in per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend[DIV_W-1] ? DIV_W'(-dividend) : dividend;
			dvs_q <= divisor[DIV_W-1] ? DIV_W'(-divisor) : divisor;
			rem_q <= '0;
			neg_q <= dividend[DIV_W-1] ^ divisor[DIV_W-1];
		end else if (busy_q) begin
			rem_q <= ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
			quo_q <= {quo_q[DIV_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = neg_q ? -$signed(quo_q) : $signed(quo_q);

endmodule

// File: src/fpest_dp.sv
// Datapath: configuration registers, working registers, shared multiplier and divider.
module fpest_dp (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [fpest_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [fpest_pkg::CFG_W-1:0]        cfg_data,
	input  logic [1:0]                         command,
	input  logic signed [30:0]                 operand,
	output logic signed [31:0]                 result,
	input  fpest_pkg::dp_cmd_t                 cmd,
	output fpest_pkg::dp_status_t              status
);
	import fpest_pkg::*;

	// Configuration registers
	logic [CFG_W-1:0] in_scale_q;
	logic [CFG_W-1:0] out_scale_q;
	logic [4:0]       term_count_q;
	logic [CFG_W-1:0] log2e_q;
	logic [CFG_W-1:0] ln2_q;

	// Working registers
	logic [1:0]          cmd_q;
	logic signed [31:0]  x_q;
	logic signed [31:0]  tmp_q;
	logic signed [31:0]  n_q;
	logic signed [31:0]  d_q;
	logic signed [31:0]  y_q;
	logic signed [31:0]  acc_q;
	logic signed [31:0]  e_q;
	logic [CFG_W-1:0]    sdiff_q;
	logic [TERM_W-1:0]   k_q;
	logic signed [63:0]  p_q;
	logic signed [31:0]  res_q;
	logic signed [31:0]  result_q;

	logic [CFG_W-1:0]          si;
	logic [34:0]               si10;
	logic signed [31:0]        xe;
	logic signed [32:0]        x33;
	logic                      tanh_zero;
	logic                      exp_zero;
	logic [TERM_W-1:0]         term_lim;
	logic signed [33:0]        ma;
	logic signed [33:0]        mb;
	logic signed [67:0]        prod;
	logic                      mul_en;
	logic signed [33:0]        so34;
	logic signed [33:0]        e34;
	logic signed [33:0]        den;
	logic signed [DIV_W-1:0]   dvd;
	logic signed [DIV_W-1:0]   dvs;
	logic                      div_done;
	logic signed [DIV_W-1:0]   quot;
	logic signed [31:0]        q32;
	logic signed [31:0]        nneg;
	logic signed [31:0]        shifted;
	logic [TERM_W:0]           kp1;

	// True when v lies below minus ten input scales
	function automatic logic below_m10(input logic signed [32:0] v, input logic [34:0] s10);
		logic signed [36:0] sum;
		sum = {{4{v[32]}}, v} + $signed({2'b00, s10});
		return sum[36];
	endfunction

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_scale_q   <= RST_INPUT_SCALE;
			out_scale_q  <= RST_OUTPUT_SCALE;
			term_count_q <= RST_TERM_COUNT;
			log2e_q      <= RST_LOG2E;
			ln2_q        <= RST_LN2;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_INPUT_SCALE:  in_scale_q   <= cfg_data;
				REG_OUTPUT_SCALE: out_scale_q  <= cfg_data;
				REG_TERM_COUNT:   term_count_q <= cfg_data[4:0];
				REG_LOG2E:        log2e_q      <= cfg_data;
				REG_LN2:          ln2_q        <= cfg_data;
				default:          ;
			endcase
		end
	end

	// Derive scale terms, exp argument and skip flags
	always_comb begin
		si   = (in_scale_q == '0) ? CFG_W'(1) : in_scale_q;
		si10 = {1'b0, si, 3'b000} + {3'b000, si, 1'b0};
		x33  = {x_q[31], x_q};
		case (cmd_q)
			CMD_SIGMOID: xe = x_q[31] ? x_q : -x_q;
			CMD_TANH:    xe = x_q[31] ? {x_q[30:0], 1'b0} : -{x_q[30:0], 1'b0};
			default:     xe = x_q;
		endcase
		tanh_zero = (cmd_q == CMD_TANH) &&
			(x_q[31] ? below_m10(x33, si10) : below_m10(-x33, si10));
		exp_zero  = below_m10({xe[31], xe}, si10);
		term_lim  = ({2'b00, term_count_q} > 7'(MAX_TERMS)) ? TERM_W'(MAX_TERMS)
		                                                   : TERM_W'(term_count_q);
		so34 = $signed({3'b000, out_scale_q});
		e34  = {{2{e_q[31]}}, e_q};
		den  = so34 + e34;
		kp1  = {1'b0, k_q} + 1'b1;
	end

	// Select multiplier operands
	always_comb begin
		ma     = '0;
		mb     = '0;
		mul_en = 1'b1;
		case (cmd.op)
			OP_MUL_XL: begin
				ma = {{2{xe[31]}}, xe};
				mb = $signed({3'b000, log2e_q});
			end
			OP_MUL_SN: begin
				ma = $signed({3'b000, si});
				mb = {{2{n_q[31]}}, n_q};
			end
			OP_MUL_T2: begin
				ma = {{2{p_q[31]}}, p_q[31:0]};
				mb = $signed({3'b000, ln2_q});
			end
			OP_MUL_YD: begin
				ma = {{2{y_q[31]}}, y_q};
				mb = {{2{d_q[31]}}, d_q};
			end
			OP_MUL_AS: begin
				ma = {{2{acc_q[31]}}, acc_q};
				mb = $signed({3'b000, sdiff_q});
			end
			OP_MUL_P: begin
				mb = so34;
				if (cmd_q == CMD_SIGMOID)
					ma = x_q[31] ? e34 : so34;
				else
					ma = x_q[31] ? (e34 - so34) : (so34 - e34);
			end
			default: mul_en = 1'b0;
		endcase
		prod = ma * mb;
	end

	// Select divider operands
	always_comb begin
		case (cmd.div_sel)
			DIV_P_SI:  begin dvd = p_q;                  dvs = $signed(DIV_W'(si)); end
			DIV_T_SI:  begin dvd = DIV_W'(tmp_q);        dvs = $signed(DIV_W'(si)); end
			DIV_Y_K:   begin dvd = DIV_W'(y_q);          dvs = $signed(DIV_W'(kp1)); end
			DIV_OS_SI: begin dvd = $signed(DIV_W'(out_scale_q)); dvs = $signed(DIV_W'(si)); end
			DIV_P_DEN: begin dvd = p_q;                  dvs = DIV_W'(den); end
			default:   begin dvd = p_q;                  dvs = $signed(DIV_W'(si)); end
		endcase
	end

	fpest_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (dvd),
		.divisor  (dvs),
		.done     (div_done),
		.quotient (quot)
	);

	// Shift the series sum by the power of two
	always_comb begin
		q32  = quot[31:0];
		nneg = -n_q;
		if (!n_q[31] && (n_q != 0))
			shifted = (|n_q[30:5]) ? 32'sd0 : (acc_q <<< n_q[4:0]);
		else if (n_q[31])
			shifted = (n_q < -32'sd31) ? $signed({32{acc_q[31]}}) : (acc_q >>> nneg[4:0]);
		else
			shifted = acc_q;
	end

	// Execute datapath commands
	always_ff @(posedge clk) begin
		if (mul_en)
			p_q <= prod[63:0];
		case (cmd.op)
			OP_LOAD: begin
				cmd_q <= command;
				x_q   <= {operand[30], operand};
			end
			OP_Q32:  tmp_q <= q32;
			OP_SETN: n_q <= q32 + {31'b0, |(tmp_q & {2'b00, si[30:1]})};
			OP_SETD: begin
				d_q   <= xe - q32;
				y_q   <= $signed({1'b0, si});
				acc_q <= $signed({1'b0, si});
				k_q   <= '0;
			end
			OP_Y1:   y_q <= q32;
			OP_Y2: begin
				y_q   <= q32;
				acc_q <= acc_q + q32;
				k_q   <= k_q + 1'b1;
			end
			OP_SHIFT: acc_q   <= shifted;
			OP_SDIFF: sdiff_q <= quot[CFG_W-1:0];
			OP_SETE:  e_q     <= p_q[31:0];
			OP_EZERO: e_q     <= '0;
			OP_RESZ:  res_q   <= '0;
			OP_RESE:  res_q   <= e_q;
			OP_RESQ:  res_q   <= q32;
			OP_OUT:   result_q <= res_q;
			default:  ;
		endcase
	end

	assign result = result_q;

	always_comb begin
		status.cmd        = cmd_q;
		status.exp_skip   = exp_zero || tanh_zero;
		status.terms_done = (k_q == term_lim);
		status.den_zero   = (den == '0);
		status.div_done   = div_done;
	end

endmodule

// File: src/fpest_ctrl.sv
// Controller: sequences range reduction, series terms and final divide; owns handshakes.
module fpest_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	output logic                  out_valid,
	input  logic                  out_stall,
	output fpest_pkg::dp_cmd_t    cmd,
	input  fpest_pkg::dp_status_t status
);
	import fpest_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_load;

	// State register and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
		end
	end

	// Next state and datapath commands
	always_comb begin
		state_d       = state_q;
		cmd.op        = OP_NONE;
		cmd.div_start = 1'b0;
		cmd.div_sel   = DIV_P_SI;
		out_load      = 1'b0;
		unique case (state_q)
			S_IDLE: if (in_valid) begin
				cmd.op  = OP_LOAD;
				state_d = S_PREP;
			end
			S_PREP: begin
				if (status.cmd == CMD_NONE) begin
					cmd.op  = OP_RESZ;
					state_d = S_OUT;
				end else if (status.exp_skip) begin
					cmd.op  = OP_EZERO;
					state_d = S_POST;
				end else begin
					state_d = S_NMUL;
				end
			end
			S_NMUL: begin
				cmd.op  = OP_MUL_XL;
				state_d = S_NDIV1;
			end
			S_NDIV1: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DIV_P_SI;
				state_d       = S_NW1;
			end
			S_NW1: begin
				cmd.div_sel = DIV_P_SI;
				if (status.div_done) begin
					cmd.op  = OP_Q32;
					state_d = S_NDIV2;
				end
			end
			S_NDIV2: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DIV_T_SI;
				state_d       = S_NW2;
			end
			S_NW2: begin
				cmd.div_sel = DIV_T_SI;
				if (status.div_done) begin
					cmd.op  = OP_SETN;
					state_d = S_SNMUL;
				end
			end
			S_SNMUL: begin
				cmd.op  = OP_MUL_SN;
				state_d = S_T2MUL;
			end
			S_T2MUL: begin
				cmd.op  = OP_MUL_T2;
				state_d = S_DDIV;
			end
			S_DDIV: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DIV_P_SI;
				state_d       = S_DW;
			end
			S_DW: begin
				cmd.div_sel = DIV_P_SI;
				if (status.div_done) begin
					cmd.op  = OP_SETD;
					state_d = S_TCHK;
				end
			end
			S_TCHK: begin
				if (status.terms_done) begin
					cmd.op  = OP_SHIFT;
					state_d = S_SDDIV;
				end else begin
					cmd.op  = OP_MUL_YD;
					state_d = S_YDIV1;
				end
			end
			S_YDIV1: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DIV_P_SI;
				state_d       = S_YW1;
			end
			S_YW1: begin
				cmd.div_sel = DIV_P_SI;
				if (status.div_done) begin
					cmd.op  = OP_Y1;
					state_d = S_YDIV2;
				end
			end
			S_YDIV2: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DIV_Y_K;
				state_d       = S_YW2;
			end
			S_YW2: begin
				cmd.div_sel = DIV_Y_K;
				if (status.div_done) begin
					cmd.op  = OP_Y2;
					state_d = S_TCHK;
				end
			end
			S_SDDIV: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DIV_OS_SI;
				state_d       = S_SDW;
			end
			S_SDW: begin
				cmd.div_sel = DIV_OS_SI;
				if (status.div_done) begin
					cmd.op  = OP_SDIFF;
					state_d = S_ASMUL;
				end
			end
			S_ASMUL: begin
				cmd.op  = OP_MUL_AS;
				state_d = S_ESET;
			end
			S_ESET: begin
				cmd.op  = OP_SETE;
				state_d = S_POST;
			end
			S_POST: begin
				if (status.cmd == CMD_EXP) begin
					cmd.op  = OP_RESE;
					state_d = S_OUT;
				end else if (status.den_zero) begin
					cmd.op  = OP_RESZ;
					state_d = S_OUT;
				end else begin
					cmd.op  = OP_MUL_P;
					state_d = S_PDIV;
				end
			end
			S_PDIV: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DIV_P_DEN;
				state_d       = S_PW;
			end
			S_PW: begin
				cmd.div_sel = DIV_P_DEN;
				if (status.div_done) begin
					cmd.op  = OP_RESQ;
					state_d = S_OUT;
				end
			end
			S_OUT: if (!out_valid_q || !out_stall) begin
				cmd.op   = OP_OUT;
				out_load = 1'b1;
				state_d  = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	// A new result appears only from the output state
	a_out_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == S_OUT))
		else $error("result raised outside output state");

	// An accepted transaction always starts preparation
	a_accept_prep: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == S_PREP))
		else $error("accepted transaction not prepared");

	// A stalled result is held
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid)
		else $error("stalled result dropped");

	// Divider is started only from a launch state
	a_div_start: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> (state_q == S_NDIV1 || state_q == S_NDIV2 ||
			state_q == S_DDIV || state_q == S_YDIV1 || state_q == S_YDIV2 ||
			state_q == S_SDDIV || state_q == S_PDIV))
		else $error("divider started outside launch state");

endmodule

// File: src/fixed_point_exp_sigmoid_tanh_top.sv
// Top level of the fixed-point exp/sigmoid/tanh evaluator.
//
//  channel   direction  handshake            payload
//  input     in         in_valid / in_stall    command, operand
//  result    out        out_valid / out_stall  result
//  config    in         cfg_we                 cfg_index, cfg_data
//
// One transaction at a time. exp runs range reduction (a multiply, two divider
// passes, two multiplies, a third pass), then per Taylor term one multiply and two
// passes of the shared divider, then a divider pass for the scale ratio; sigmoid
// and tanh add one multiply and divide. Zero cases skip range reduction and series;
// unused commands go straight to output. Reset restores register defaults at once.
// A finished result waits in the output register while the next transaction runs.
module fixed_point_exp_sigmoid_tanh_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [1:0]                      command,
	input  logic signed [30:0]              operand,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic signed [31:0]              result,
	input  logic                            cfg_we,
	input  logic [fpest_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [fpest_pkg::CFG_W-1:0]     cfg_data
);
	import fpest_pkg::*;

	dp_cmd_t    dp_cmd;
	dp_status_t dp_status;

	fpest_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (dp_cmd),
		.status    (dp_status)
	);

	fpest_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.command   (command),
		.operand   (operand),
		.result    (result),
		.cmd       (dp_cmd),
		.status    (dp_status)
	);

endmodule
